### hw/rtl/okrl_pkg.sv
// ----------------------------------------------------------------------------
// okrl_pkg: shared types and constants of the ordered keyed record list
// command and status codes, field widths and the controller/datapath
// interface structs
// ----------------------------------------------------------------------------
package okrl_pkg;

   // default configuration
   localparam int DEPTH_DEF    = 16;
   localparam int KEY_BITS_DEF = 16;

   // field widths
   localparam int CMD_W     = 3;
   localparam int IN_KEY_W  = 16;
   localparam int VAL_W     = 9;
   localparam int STATUS_W  = 2;
   localparam int OUT_KEY_W = 16;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int REQ_PAD_W  = REQ_DATA_W - CMD_W - IN_KEY_W - VAL_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - OUT_KEY_W - VAL_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic                load_item;   // latch the accepted item
      logic                clr_rd;      // restart the walk at entry zero
      logic                start_shift; // restart the walk after the match
      logic                rd_issue;    // read the entry at the walk index
      logic                consume;     // the read data has been used
      logic                wr_insert;   // append the item at the tail
      logic                wr_shift;    // move the read entry down by one
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_clr;
      logic                emit;        // load a result into the output register
      logic                emit_data;   // result carries the read record
      logic                emit_last;
      logic [STATUS_W-1:0] emit_status;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd_code;
      logic             count_zero;
      logic             full;
      logic             dv;          // read data register holds an entry
      logic             match;       // read entry key equals the item key
      logic             d_last;      // read entry is the tail entry
      logic             rd_more;     // walk index still below the count
      logic             slot_free;   // output register can take a result
   } dp_status_type;

endpackage

### hw/rtl/okrl_datapath.sv
// ----------------------------------------------------------------------------
// okrl_datapath: record memory, entry count, walk pointers and result register
// one registered read port and one write port; the walk issues one read a
// cycle unless stalled, and the read data register acts as a pipeline stage
// ----------------------------------------------------------------------------
module okrl_datapath #(
   parameter int DEPTH    = okrl_pkg::DEPTH_DEF,
   parameter int KEY_BITS = okrl_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [okrl_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  okrl_pkg::dp_cmd_type              cmd,
   output okrl_pkg::dp_status_type           stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [okrl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = KEY_BITS + okrl_pkg::VAL_W;

   // latched item
   logic [okrl_pkg::CMD_W-1:0] cmd_code_ff;
   logic [KEY_BITS-1:0]        item_key_ff;
   logic [okrl_pkg::VAL_W-1:0] item_value_ff;

   // table state and walk
   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  d_idx_ff;
   logic              dv_ff, dv_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [okrl_pkg::STATUS_W-1:0] status_ff;
   logic [okrl_pkg::OUT_KEY_W-1:0] out_key_ff;
   logic [okrl_pkg::VAL_W-1:0]    out_value_ff;
   logic                          last_ff;

   logic [KEY_BITS-1:0]        rd_key;
   logic [okrl_pkg::VAL_W-1:0] rd_value;
   logic                       slot_free;
   logic [IDX_W-1:0]           wr_addr;
   logic [WORD_W-1:0]          wr_word;

   assign rd_key    = rd_data_ff[WORD_W-1 -: KEY_BITS];
   assign rd_value  = rd_data_ff[okrl_pkg::VAL_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // status toward the controller
   always_comb begin
      stat.cmd_code   = cmd_code_ff;
      stat.count_zero = (count_ff == '0);
      stat.full       = (count_ff >= CNT_W'(DEPTH));
      stat.dv         = dv_ff;
      stat.match      = (rd_key == item_key_ff);
      stat.d_last     = ((d_idx_ff + CNT_W'(1)) == count_ff);
      stat.rd_more    = (rd_idx_ff < count_ff);
      stat.slot_free  = slot_free;
   end

   // latch the accepted item, key masked to the stored width
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_code_ff   <= req_tdata[okrl_pkg::CMD_W-1:0];
         item_key_ff   <= KEY_BITS'(req_tdata[okrl_pkg::CMD_W +: okrl_pkg::IN_KEY_W]);
         item_value_ff <= req_tdata[okrl_pkg::CMD_W + okrl_pkg::IN_KEY_W +: okrl_pkg::VAL_W];
      end
   end

   // next values of count, walk index and read valid
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      rd_idx_in = rd_idx_ff;
      dv_in     = dv_ff;
      if (cmd.clr_rd) begin
         rd_idx_in = '0;
         dv_in     = 1'b0;
      end else if (cmd.start_shift) begin
         rd_idx_in = d_idx_ff + CNT_W'(1);
         dv_in     = 1'b0;
      end else if (cmd.rd_issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
         dv_in     = 1'b1;
      end else if (cmd.consume) begin
         dv_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (cmd.rd_issue && !cmd.clr_rd && !cmd.start_shift) begin
         d_idx_ff <= rd_idx_ff;
      end
   end

   // write port: append at the tail or move an entry down one place
   always_comb begin
      if (cmd.wr_shift) begin
         wr_addr = IDX_W'(d_idx_ff - CNT_W'(1));
         wr_word = rd_data_ff;
      end else begin
         wr_addr = count_ff[IDX_W-1:0];
         wr_word = {item_key_ff, item_value_ff};
      end
   end

   // record memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_insert || cmd.wr_shift) begin
         mem_ff[wr_addr] <= wr_word;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff <= cmd.emit_status;
         last_ff   <= cmd.emit_last;
         if (cmd.emit_data) begin
            out_key_ff   <= okrl_pkg::OUT_KEY_W'(rd_key);
            out_value_ff <= rd_value;
         end else begin
            out_key_ff   <= '0;
            out_value_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{okrl_pkg::RSP_PAD_W{1'b0}}, out_value_ff, out_key_ff, status_ff};

`ifndef SYNTHESIS
   // count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // held read data always comes from a live entry
   a_read_live: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (d_idx_ff < count_ff))
      else $error("read data from an entry beyond the count");

   // reads are issued only below the count
   a_issue_live: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> (rd_idx_ff < count_ff))
      else $error("read issued beyond the count");

   // an append never happens on a full table
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff < CNT_W'(DEPTH)))
      else $error("append on a full table");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> slot_free)
      else $error("result register overwritten");
`endif

endmodule

### hw/rtl/okrl_ctrl.sv
// ----------------------------------------------------------------------------
// okrl_ctrl: command sequencer of the ordered keyed record list
// decodes one item, walks the table through the datapath and issues results
// ----------------------------------------------------------------------------
module okrl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  okrl_pkg::dp_status_type  stat,
   output okrl_pkg::dp_cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_SCAN  = 6'b000100,
      S_FOUND = 6'b001000,
      S_DUMP  = 6'b010000,
      S_SHIFT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.emit_last     = 1'b1;
      cmd.emit_status   = okrl_pkg::ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_START;
            end
         end

         // decode the latched command
         S_START: begin
            case (stat.cmd_code)
               okrl_pkg::CMD_INSERT: begin
                  if (stat.slot_free) begin
                     cmd.emit = 1'b1;
                     if (stat.full) begin
                        cmd.emit_status = okrl_pkg::ST_FULL;
                     end else begin
                        cmd.wr_insert = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               okrl_pkg::CMD_CLEAR: begin
                  if (stat.slot_free) begin
                     cmd.emit    = 1'b1;
                     cmd.cnt_clr = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
               okrl_pkg::CMD_SEARCH, okrl_pkg::CMD_DELETE, okrl_pkg::CMD_DUMP: begin
                  if (stat.count_zero) begin
                     if (stat.slot_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = okrl_pkg::ST_EMPTY;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.clr_rd = 1'b1;
                     state_in   = (stat.cmd_code == okrl_pkg::CMD_DUMP) ? S_DUMP : S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // compare one entry a cycle, stop on the first match
         S_SCAN: begin
            if (stat.dv && stat.match) begin
               state_in = S_FOUND;
            end else if (stat.dv && stat.d_last) begin
               if (stat.slot_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = okrl_pkg::ST_NOT_FOUND;
                  cmd.consume     = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.consume  = stat.dv;
               cmd.rd_issue = stat.rd_more;
            end
         end

         // report the match, then close the gap on delete
         S_FOUND: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_data = 1'b1;
               if (stat.cmd_code == okrl_pkg::CMD_DELETE) begin
                  cmd.start_shift = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.consume = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end

         // stream every entry out, held back by the result register
         S_DUMP: begin
            if (stat.dv && stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_data = 1'b1;
               cmd.emit_last = stat.d_last;
               cmd.consume   = 1'b1;
               if (stat.d_last) begin
                  state_in = S_IDLE;
               end
            end
            cmd.rd_issue = stat.rd_more && (!stat.dv || stat.slot_free);
         end

         // copy each later entry one place down
         S_SHIFT: begin
            if (stat.dv) begin
               cmd.wr_shift = 1'b1;
               cmd.consume  = 1'b1;
            end
            cmd.rd_issue = stat.rd_more;
            if (!stat.dv && !stat.rd_more) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/ordered_keyed_record_list_top.sv
// ----------------------------------------------------------------------------
// ordered_keyed_record_list_top: insertion-ordered key/value record table
// Takes one command item at a time on the req_ stream and returns its
// results on the rsp_ stream. Insert and clear return a single result, and
// so do search, delete and dump on an empty table. Search walks the stored
// entries in order and stops at the first hit or at the tail entry: the
// table sits in one memory with a registered read port and the walk reads one
// entry per cycle. Delete returns its result the same way, then copies each
// later entry down one place at the same rate before the next item is
// accepted. Dump returns every entry in order, one per cycle while
// rsp_tready stays high. Apart from the delete shift, the next item is
// accepted as soon as the last result of the current one is in the output
// register, while that result still waits to be taken.
// ----------------------------------------------------------------------------
module ordered_keyed_record_list_top #(
   parameter int DEPTH    = okrl_pkg::DEPTH_DEF,
   parameter int KEY_BITS = okrl_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cmd[2:0], record_key[18:3], record_value[27:19], zero[31:28]
   input  logic [okrl_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], out_key[17:2], out_value[26:18], zero[31:27]
   output logic [okrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   okrl_pkg::dp_cmd_type    cmd;
   okrl_pkg::dp_status_type stat;

   // sequencer
   okrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table and result register
   okrl_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
